[rtl/core/brse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brse_pkg
// Shared types and constants of the block run/size symbol encoder.
// ----------------------------------------------------------------------------
package brse_pkg;

    localparam int unsigned MAG_BITS   = 15;
    localparam int unsigned SIZE_BITS  = 4;
    localparam int unsigned POS_BITS   = 6;
    localparam int unsigned SYM_BITS   = 8;
    localparam int unsigned COMP_BITS  = 2;
    localparam int unsigned ZCNT_BITS  = 2;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QPTR_BITS  = $clog2(QDEPTH);
    localparam int unsigned QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam logic [SYM_BITS-1:0] SYM_ZRL  = 8'hF0;
    localparam logic [SYM_BITS-1:0] SYM_EOB  = 8'h00;
    localparam logic [POS_BITS-1:0] LAST_POS = 6'd63;

    // One queued job: zrl_cnt ZRL symbols, then the final symbol.
    typedef struct packed {
        logic [ZCNT_BITS-1:0] zrl_cnt;
        logic [SYM_BITS-1:0]  symbol;
        logic                 is_dc;
        logic [COMP_BITS-1:0] comp;
        logic [MAG_BITS-1:0]  extra_bits;
        logic [SIZE_BITS-1:0] extra_len;
    } job_t;

    // Queue status toward the back end.
    typedef struct packed {
        logic valid;
    } q_ctl_t;

endpackage : brse_pkg
`default_nettype wire

[rtl/core/brse_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brse_front
// Accept coefficients, track scan position and zero run, build symbol jobs.
// ----------------------------------------------------------------------------
module brse_front #(
    parameter int unsigned COEF_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [COEF_BITS-1:0]        in_coef,
    input  wire logic [brse_pkg::COMP_BITS-1:0] in_comp,
    output logic                             push,
    input  wire logic                        q_full,
    output brse_pkg::job_t                   push_job
);
    import brse_pkg::*;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] run_reg, run_next;

    logic signed [32:0]         coef_ext;
    logic signed [MAG_BITS:0]   v;
    logic [MAG_BITS-1:0]        mag;
    logic [MAG_BITS:0]          mant;
    logic [MAG_BITS:0]          mask;
    logic [SIZE_BITS-1:0]       n;
    logic                       accept;
    logic                       emit;
    job_t                       job;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb begin
        coef_ext = {{(33 - COEF_BITS){in_coef[COEF_BITS-1]}}, in_coef};
        // Clamp to the symmetric 16-bit range.
        if (coef_ext > 33'sd32767) begin
            v = 16'sd32767;
        end else if (coef_ext < -33'sd32767) begin
            v = -16'sd32767;
        end else begin
            v = coef_ext[MAG_BITS:0];
        end
        mag  = v[MAG_BITS] ? MAG_BITS'(-v) : v[MAG_BITS-1:0];
        mant = v[MAG_BITS] ? (MAG_BITS+1)'(v - 16'sd1) : v;
        n    = '0;
        for (int i = 0; i < MAG_BITS; i++) begin
            if (mag[i]) n = SIZE_BITS'(i + 1);
        end
        mask = ((MAG_BITS+1)'(1) << n) - (MAG_BITS+1)'(1);
    end

    always_comb begin
        job            = '0;
        job.comp       = in_comp;
        emit           = 1'b0;
        run_next       = run_reg;
        if (pos_reg == '0) begin
            job.symbol     = SYM_BITS'(n);
            job.is_dc      = 1'b1;
            job.extra_bits = mask[MAG_BITS-1:0] & mant[MAG_BITS-1:0];
            job.extra_len  = n;
            emit           = 1'b1;
            run_next       = '0;
        end else if (mag == '0) begin
            run_next = run_reg + POS_BITS'(1);
            if (pos_reg == LAST_POS) begin
                job.symbol = SYM_EOB;
                emit       = 1'b1;
            end
        end else begin
            job.zrl_cnt    = run_reg[5:4];
            job.symbol     = {run_reg[3:0], n};
            job.extra_bits = mask[MAG_BITS-1:0] & mant[MAG_BITS-1:0];
            job.extra_len  = n;
            emit           = 1'b1;
            run_next       = '0;
        end
        if (pos_reg == LAST_POS) begin
            pos_next = '0;
            run_next = '0;
        end else begin
            pos_next = pos_reg + POS_BITS'(1);
        end
    end

    assign push     = accept && emit;
    assign push_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            run_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
            run_reg <= run_next;
        end
    end

endmodule : brse_front
`default_nettype wire

[rtl/core/brse_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brse_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module brse_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire brse_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output brse_pkg::q_ctl_t     head_ctl,
    output brse_pkg::job_t       head_job
);
    import brse_pkg::*;

    job_t                 entry_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_pop;

    assign full           = (count_reg == QCNT_BITS'(QDEPTH));
    assign head_ctl.valid = (count_reg != '0);
    assign head_job       = entry_reg[rd_ptr_reg];
    assign do_pop         = pop && head_ctl.valid;

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (do_pop)        rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            if ((push && !full) && !do_pop) begin
                count_reg <= count_reg + QCNT_BITS'(1);
            end else if (do_pop && !(push && !full)) begin
                count_reg <= count_reg - QCNT_BITS'(1);
            end
        end
    end

endmodule : brse_queue
`default_nettype wire

[rtl/core/brse_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brse_back
// Expand each job into its ZRL symbols and final symbol, one per cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
module brse_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire brse_pkg::q_ctl_t head_ctl,
    input  wire brse_pkg::job_t   head_job,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output brse_pkg::job_t       out_job,
    output logic                 out_last
);
    import brse_pkg::*;

    logic                 valid_reg;
    job_t                 job_reg;
    logic                 last_reg;
    logic [ZCNT_BITS-1:0] zsent_reg;
    logic                 load;
    logic                 zrl_step;
    job_t                 zrl_job;

    assign load     = head_ctl.valid && (!valid_reg || out_ready);
    assign zrl_step = (zsent_reg != head_job.zrl_cnt);
    assign pop      = load && !zrl_step;

    always_comb begin
        zrl_job        = '0;
        zrl_job.symbol = SYM_ZRL;
        zrl_job.comp   = head_job.comp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            zsent_reg <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                zsent_reg <= zrl_step ? zsent_reg + ZCNT_BITS'(1) : '0;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg  <= zrl_step ? zrl_job : head_job;
            last_reg <= !zrl_step;
        end
    end

    assign out_valid = valid_reg;
    assign out_job   = job_reg;
    assign out_last  = last_reg;

endmodule : brse_back
`default_nettype wire

[rtl/core/block_run_size_symbol_encoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// block_run_size_symbol_encoder_top
// Run/size symbol encoder for 8x8 coefficient blocks in scan order.
// ----------------------------------------------------------------------------
// Feed the 64 coefficients of each block in scan order, one transfer each, with
// the component on tuser. The first coefficient of a block yields a DC size
// symbol; zero AC coefficients yield nothing until a nonzero one arrives, which
// yields one ZRL (0xF0) per 16 pending zeros and then its run/size symbol; a
// block that ends on zeros yields an end-of-block symbol (0x00). tlast marks
// the final result of each input transfer. The input takes one coefficient per
// cycle while the 4-entry job queue has room; the output gives one result per
// cycle while jobs wait and results are taken: first each ZRL a coefficient
// carries, then its final symbol (up to four in all). ZRL bursts and stalls
// on the result channel fill the queue, and only a full queue backs up the
// input. A coefficient's first result passes through the job queue and then
// the output register. Inputs are sign-extended from COEF_BITS and clamped
// to +/-32767.
// ----------------------------------------------------------------------------
module block_run_size_symbol_encoder_top #(
    parameter int unsigned COEF_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input channel
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: coefficient (COEF_BITS, signed), zero padding to whole bytes
    input  wire logic [((COEF_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // tuser: component [1:0]
    input  wire logic [1:0]                          s_axis_tuser,
    // Result channel
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: symbol [7:0], extra_bits [22:8], extra_len [26:23], zeros [31:27]
    output logic [31:0]                              m_axis_tdata,
    // tuser: is_dc [0], table_component [2:1]
    output logic [2:0]                               m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import brse_pkg::*;

    logic     push;
    logic     q_full;
    logic     pop;
    job_t     push_job;
    job_t     head_job;
    job_t     out_job;
    q_ctl_t   head_ctl;
    logic     out_last;

    // Front end: classify each coefficient and queue a job when it yields output.
    brse_front #(
        .COEF_BITS (COEF_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_coef  (s_axis_tdata[COEF_BITS-1:0]),
        .in_comp  (s_axis_tuser),
        .push     (push),
        .q_full   (q_full),
        .push_job (push_job)
    );

    // Job queue: hold work while the back end drains ZRL bursts.
    brse_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head_ctl (head_ctl),
        .head_job (head_job)
    );

    // Back end: expand jobs into results through the output register.
    brse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_ctl  (head_ctl),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_job   (out_job),
        .out_last  (out_last)
    );

    // Pack result fields, lowest field first.
    assign m_axis_tdata = {5'b0, out_job.extra_len, out_job.extra_bits, out_job.symbol};
    assign m_axis_tuser = {out_job.comp, out_job.is_dc};
    assign m_axis_tlast = out_last;

endmodule : block_run_size_symbol_encoder_top
`default_nettype wire
